FILE: src/arpce_pkg.sv
// arpce_pkg: shared constants and types for the arp cache engine
// no dependencies; used by arp_cache_engine_unit
package arpce_pkg;

    // cache geometry
    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    // stream payload widths
    localparam int S_DATA_W = 176;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // protocol constants
    localparam logic [31:0] BCAST_IP    = 32'hFFFF_FFFF;
    localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] MIN_PKT_LEN = 16'd28;
    localparam logic [15:0] HW_ETHERNET = 16'd1;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'd1;

    // aging: age/18 > ttl  <=>  age > 18*ttl + 17
    localparam int TICKS_PER_SEC = 18;
    localparam int TTL_LIM_W     = 21;
    localparam logic [15:0] TTL_RESET = 16'd300;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL    = 8'd1;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_PACKET = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_TICK    = 3'd0,
        ST_HIT     = 3'd1,
        ST_MISS    = 3'd2,
        ST_REPLY   = 3'd3,
        ST_LEARNED = 3'd4,
        ST_DROP    = 3'd5
    } t_status;

endpackage

FILE: src/arp_cache_engine_unit.sv
// arp_cache_engine_unit: ipv4-to-mac cache with tick based aging
// depends on arpce_pkg for constants, codes and widths
//
// usage:
//   slave stream (i_s_*) takes one request: tuser is the kind (tick, arp
//   packet, lookup), tdata carries the packet or lookup fields.
//   master stream (o_m_*) returns one result per tick, packet or lookup
//   request: tuser is the status, tdata the resolved mac and reply ip.
//   the config channel (i_cfg_*) writes own_ip (index 0) and ttl_seconds
//   (index 1); it is always ready; the user must write it only while idle, the block does not enforce this.
// timing:
//   one request at a time; a single ip/timestamp compare unit walks the
//   entries one per cycle under a small sequencer.
//   tick, drop and broadcast lookup go straight to the result state
//   lookup: one scan over N entries, stopping at a live hit
//   packet learn: match/free scan, then oldest scan if no slot was free
//   here N = 16 entries.
// reset clears valid bits, tick counter and own_ip and sets the default ttl at once; no sweep.
// a result waits in the output register while the receiver stalls; the
// next request is accepted meanwhile and finishes when the register frees.
module arp_cache_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // addr_ip[31:0], tgt_ip[63:32], src_mac[111:64], hw_type[127:112],
    // ptype[143:128], opcode[159:144], pkt_len[175:160]
    input  logic [arpce_pkg::S_DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [arpce_pkg::S_USER_W-1:0]  i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // mac_out[47:0], reply_ip[79:48]
    output logic [arpce_pkg::M_DATA_W-1:0]  o_m_tdata,
    // status[2:0]
    output logic [arpce_pkg::M_USER_W-1:0]  o_m_tuser,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [arpce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arpce_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int N    = arpce_pkg::CACHE_ENTRIES;
    localparam int IW   = arpce_pkg::IDX_W;
    localparam int TLW  = arpce_pkg::TTL_LIM_W;
    localparam int M_DW = arpce_pkg::M_DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_MATCH,
        S_SCAN_OLD,
        S_WRITE,
        S_LOOK,
        S_FIN
    } t_state;

    // sequencer and request registers
    t_state                 r_state;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_slot;
    logic                   r_free_found;
    logic [31:0]            r_best;
    logic [31:0]            r_ip;
    logic [47:0]            r_mac;
    logic [31:0]            r_tick;

    // pending result
    arpce_pkg::t_status     r_res_status;
    logic [47:0]            r_res_mac;
    logic [31:0]            r_res_ip;

    // output register
    logic                   r_m_valid;
    logic [M_DW-1:0]        r_m_data;
    logic [2:0]             r_m_user;

    // config
    logic [31:0]            r_own_ip;
    logic [TLW-1:0]         r_ttl_lim;

    // cache storage
    logic [N-1:0]           r_ent_valid;
    logic [31:0]            r_ent_ip   [N];
    logic [47:0]            r_ent_mac  [N];
    logic [31:0]            r_ent_time [N];

    // unpacked request fields
    arpce_pkg::t_kind       w_kind;
    logic [31:0]            w_in_ip;
    logic [31:0]            w_in_tgt;
    logic [47:0]            w_in_mac;
    logic [15:0]            w_in_hw;
    logic [15:0]            w_in_proto;
    logic [15:0]            w_in_op;
    logic [15:0]            w_in_len;
    logic                   w_accept;

    assign w_kind     = arpce_pkg::t_kind'(i_s_tuser);
    assign w_in_ip    = i_s_tdata[31:0];
    assign w_in_tgt   = i_s_tdata[63:32];
    assign w_in_mac   = i_s_tdata[111:64];
    assign w_in_hw    = i_s_tdata[127:112];
    assign w_in_proto = i_s_tdata[143:128];
    assign w_in_op    = i_s_tdata[159:144];
    assign w_in_len   = i_s_tdata[175:160];

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // shared compare unit on the entry under the scan index
    logic                   w_last;
    logic                   w_match;
    logic                   w_older;
    logic [31:0]            w_age;
    logic                   w_expired;
    logic                   w_drop;
    logic                   w_owe;
    logic                   w_out_free;

    assign w_last    = (r_idx == IW'(N - 1));
    assign w_match   = r_ent_valid[r_idx] && (r_ent_ip[r_idx] == r_ip);
    assign w_older   = (r_ent_time[r_idx] < r_best);
    assign w_age     = r_tick - r_ent_time[r_idx];
    assign w_expired = (w_age > {{(32 - TLW){1'b0}}, r_ttl_lim});

    assign w_drop = (w_in_len < arpce_pkg::MIN_PKT_LEN) ||
                    (w_in_hw != arpce_pkg::HW_ETHERNET) ||
                    (w_in_proto != arpce_pkg::PROTO_IPV4);
    assign w_owe  = (w_in_op == arpce_pkg::OP_REQUEST) && (w_in_tgt == r_own_ip);

    assign w_out_free = !r_m_valid || i_m_tready;

    // config registers; ttl kept as the aging limit 18*ttl + 17
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_ttl_lim <= TLW'(arpce_pkg::TTL_RESET) * TLW'(arpce_pkg::TICKS_PER_SEC)
                         + TLW'(arpce_pkg::TICKS_PER_SEC - 1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                arpce_pkg::CFG_OWN_IP: r_own_ip <= i_cfg_data;
                arpce_pkg::CFG_TTL: begin
                    r_ttl_lim <= TLW'(i_cfg_data[15:0]) * TLW'(arpce_pkg::TICKS_PER_SEC)
                                 + TLW'(arpce_pkg::TICKS_PER_SEC - 1);
                end
                default: ;
            endcase
        end
    end

    // cache payload storage, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN_MATCH && w_match) begin
            r_ent_mac[r_idx]  <= r_mac;
            r_ent_time[r_idx] <= r_tick;
        end else if (r_state == S_WRITE) begin
            r_ent_ip[r_slot]   <= r_ip;
            r_ent_mac[r_slot]  <= r_mac;
            r_ent_time[r_slot] <= r_tick;
        end
    end

    // sequencer, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_slot       <= '0;
            r_free_found <= 1'b0;
            r_tick       <= '0;
            r_ent_valid  <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            // drain the output register unless a new result replaces it
            if (r_m_valid && i_m_tready && r_state != S_FIN) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ip         <= w_in_ip;
                        r_mac        <= w_in_mac;
                        r_idx        <= '0;
                        r_free_found <= 1'b0;
                        unique case (w_kind)
                            arpce_pkg::KIND_TICK: begin
                                r_tick       <= r_tick + 32'd1;
                                r_res_status <= arpce_pkg::ST_TICK;
                                r_res_mac    <= '0;
                                r_res_ip     <= '0;
                                r_state      <= S_FIN;
                            end
                            arpce_pkg::KIND_PACKET: begin
                                if (w_drop) begin
                                    r_res_status <= arpce_pkg::ST_DROP;
                                    r_res_mac    <= '0;
                                    r_res_ip     <= '0;
                                    r_state      <= S_FIN;
                                end else begin
                                    if (w_owe) begin
                                        r_res_status <= arpce_pkg::ST_REPLY;
                                        r_res_mac    <= w_in_mac;
                                        r_res_ip     <= w_in_ip;
                                    end else begin
                                        r_res_status <= arpce_pkg::ST_LEARNED;
                                        r_res_mac    <= '0;
                                        r_res_ip     <= '0;
                                    end
                                    r_state <= S_SCAN_MATCH;
                                end
                            end
                            arpce_pkg::KIND_LOOKUP: begin
                                r_res_ip <= '0;
                                if (w_in_ip == arpce_pkg::BCAST_IP) begin
                                    r_res_status <= arpce_pkg::ST_HIT;
                                    r_res_mac    <= arpce_pkg::BCAST_MAC;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_res_status <= arpce_pkg::ST_MISS;
                                    r_res_mac    <= '0;
                                    r_state      <= S_LOOK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // learn pass one: existing entry or first free slot
                S_SCAN_MATCH: begin
                    if (w_match) begin
                        r_state <= S_FIN;
                    end else begin
                        if (!r_ent_valid[r_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_slot       <= r_idx;
                        end
                        if (w_last) begin
                            if (r_free_found) begin
                                r_state <= S_WRITE;
                            end else if (!r_ent_valid[r_idx]) begin
                                r_state <= S_WRITE;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_SCAN_OLD;
                            end
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end

                // learn pass two: lowest slot with the smallest timestamp
                S_SCAN_OLD: begin
                    if (r_idx == '0) begin
                        r_best <= r_ent_time[r_idx];
                        r_slot <= r_idx;
                    end else if (w_older) begin
                        r_best <= r_ent_time[r_idx];
                        r_slot <= r_idx;
                    end
                    if (w_last) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                S_WRITE: begin
                    r_ent_valid[r_slot] <= 1'b1;
                    r_state             <= S_FIN;
                end

                // lookup scan, aging out stale matches on the way
                S_LOOK: begin
                    if (w_match && !w_expired) begin
                        r_res_status <= arpce_pkg::ST_HIT;
                        r_res_mac    <= r_ent_mac[r_idx];
                        r_state      <= S_FIN;
                    end else begin
                        if (w_match) begin
                            r_ent_valid[r_idx] <= 1'b0;
                        end
                        if (w_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end

                // hand the result to the output register
                S_FIN: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= r_res_status;
                        r_m_data  <= {r_res_ip, r_res_mac};
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
